/* design/ufs_pkg.sv */
// ----------------------------------------------------------------------------
// ufs_pkg
// Shared types and constants of the UTF-8 frequency scorer.
// ----------------------------------------------------------------------------
package ufs_pkg;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_BYTE   = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;

  localparam logic [7:0] ASCII_MAX  = 8'h7F;
  localparam logic [7:0] LEAD_SKIP  = 8'hF0;
  localparam logic [7:0] LEAD_THREE = 8'hE0;
  localparam logic [7:0] LEAD_TWO   = 8'hC0;
  localparam logic [7:0] NIBBLE_LO  = 8'h0F;

  localparam int KEY_W   = 21;
  localparam int SUM_W   = 32;
  localparam int COUNT_W = 24;
  localparam int MEAN_W  = 24;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_FINISH = 2'd2
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key;
    logic [7:0]       score;
    logic [2:0]       omitted;
  } job_t;

endpackage

/* design/utf8_frequency_scorer.sv */
// ----------------------------------------------------------------------------
// utf8_frequency_scorer
// Scores UTF-8 text against a loaded, sorted character-weight table.
// ----------------------------------------------------------------------------
// A complete character costs a binary search in the back end: each table
// probe steps through the probe, wait and compare states, up to
// log2(fill)+1 probes, set by the single read port of the table memory.
// Finish runs a one-bit-a-cycle divider of 32+FRACTION_BITS steps. A
// two-entry queue decouples parser and back end.
module utf8_frequency_scorer #(
  parameter int TABLE_DEPTH   = 4096,
  parameter int FRACTION_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [1:0]   in_command,
  input  logic [7:0]   in_text_byte,
  input  logic [4:0]   in_entry_class,
  input  logic [15:0]  in_entry_code,
  input  logic [7:0]   in_entry_score,
  input  logic [2:0]   in_omitted_bytes,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [31:0]  out_score_total,
  output logic [23:0]  out_char_total,
  output logic [23:0]  out_mean_score
);
  import ufs_pkg::*;

  logic q_wv, q_wr, q_rv, q_rr;
  job_t q_wj, q_rj;

  ufs_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_command, .in_text_byte,
    .in_entry_class, .in_entry_code, .in_entry_score, .in_omitted_bytes,
    .job_valid(q_wv), .job_ready(q_wr), .job(q_wj)
  );

  ufs_queue u_queue (
    .clk, .rst_n, .wr_valid(q_wv), .wr_ready(q_wr), .wr_job(q_wj),
    .rd_valid(q_rv), .rd_ready(q_rr), .rd_job(q_rj)
  );

  ufs_back #(.TABLE_DEPTH(TABLE_DEPTH), .FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk, .rst_n, .job_valid(q_rv), .job_ready(q_rr), .job(q_rj),
    .out_valid, .out_ready, .out_score_total, .out_char_total, .out_mean_score
  );

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_score_total))
    else $error("result dropped while stalled");
  a_mean_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_char_total == 24'd0 |-> out_mean_score == 24'd0)
    else $error("mean non-zero with no characters");

endmodule

/* design/ufs_front.sv */
// ----------------------------------------------------------------------------
// ufs_front
// Accepts items, parses UTF-8 bytes into character keys and issues jobs.
// ----------------------------------------------------------------------------
module ufs_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_command,
  input  logic [7:0]    in_text_byte,
  input  logic [4:0]    in_entry_class,
  input  logic [15:0]   in_entry_code,
  input  logic [7:0]    in_entry_score,
  input  logic [2:0]    in_omitted_bytes,
  output logic          job_valid,
  input  logic          job_ready,
  output ufs_pkg::job_t job
);
  import ufs_pkg::*;

  typedef enum logic [1:0] {K_NONE, K_TWO, K_THREE, K_SKIP} kind_t;

  kind_t      kind_r, kind_nxt;
  logic [2:0] pend_r, pend_nxt;
  logic [7:0] lead_r, lead_nxt, mid_r, mid_nxt;
  logic       acc, emit;
  logic [4:0] cls3;

  assign in_ready = job_ready;
  assign acc      = in_valid && in_ready;
  assign cls3     = 5'd1 + {1'b0, lead_r[3:0] & NIBBLE_LO[3:0]};

  always_comb begin
    kind_nxt = kind_r;
    pend_nxt = pend_r;
    lead_nxt = lead_r;
    mid_nxt  = mid_r;
    emit     = 1'b0;
    job.op      = OP_LOAD;
    job.key     = {in_entry_class, in_entry_code};
    job.score   = in_entry_score;
    job.omitted = in_omitted_bytes;
    unique case (in_command)
      CMD_LOAD: emit = 1'b1;
      CMD_FINISH: begin
        emit = 1'b1;
        job.op = OP_FINISH;
        kind_nxt = K_NONE;
        pend_nxt = '0;
        lead_nxt = '0;
        mid_nxt  = '0;
      end
      CMD_BYTE: begin
        if (pend_r != 3'd0) begin
          pend_nxt = pend_r - 3'd1;
          priority case (kind_r)
            K_TWO: begin
              emit = 1'b1;
              job.op = OP_LOOKUP;
              job.key = {5'd0, lead_r, in_text_byte};
              kind_nxt = K_NONE;
              pend_nxt = '0;
            end
            K_THREE: begin
              if (pend_r == 3'd2) begin
                mid_nxt = in_text_byte;
              end else begin
                emit = 1'b1;
                job.op = OP_LOOKUP;
                job.key = {cls3, mid_r, in_text_byte};
                kind_nxt = K_NONE;
                pend_nxt = '0;
              end
            end
            default: begin
              if (pend_r == 3'd1) kind_nxt = K_NONE;
            end
          endcase
        end else if (in_text_byte > ASCII_MAX) begin
          if ((in_text_byte & LEAD_SKIP) == LEAD_SKIP) begin
            kind_nxt = K_SKIP;
            pend_nxt = 3'd3;
          end else if ((in_text_byte & LEAD_THREE) == LEAD_THREE) begin
            kind_nxt = K_THREE;
            lead_nxt = in_text_byte;
            pend_nxt = 3'd2;
          end else if ((in_text_byte & LEAD_TWO) == LEAD_TWO) begin
            kind_nxt = K_TWO;
            lead_nxt = in_text_byte;
            pend_nxt = 3'd1;
          end else begin
            kind_nxt = K_SKIP;
            pend_nxt = 3'd4;
          end
        end
      end
      default: ;
    endcase
  end

  assign job_valid = in_valid && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= K_NONE;
      pend_r <= '0;
      lead_r <= '0;
      mid_r  <= '0;
    end else if (acc) begin
      kind_r <= kind_nxt;
      pend_r <= pend_nxt;
      lead_r <= lead_nxt;
      mid_r  <= mid_nxt;
    end
  end

endmodule

/* design/ufs_queue.sv */
// ----------------------------------------------------------------------------
// ufs_queue
// Two-entry job queue between the parser and the table engine.
// ----------------------------------------------------------------------------
module ufs_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  ufs_pkg::job_t wr_job,
  output logic          rd_valid,
  input  logic          rd_ready,
  output ufs_pkg::job_t rd_job
);
  import ufs_pkg::*;

  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_job   = mem_r[rp_r];
  assign wr       = wr_valid && wr_ready;
  assign rd       = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_job;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

/* design/ufs_back.sv */
// ----------------------------------------------------------------------------
// ufs_back
// Table store, binary search, accumulation and restoring mean division.
// ----------------------------------------------------------------------------
module ufs_back #(
  parameter int TABLE_DEPTH   = 4096,
  parameter int FRACTION_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         job_valid,
  output logic                         job_ready,
  input  ufs_pkg::job_t                job,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ufs_pkg::SUM_W-1:0]    out_score_total,
  output logic [ufs_pkg::COUNT_W-1:0]  out_char_total,
  output logic [ufs_pkg::MEAN_W-1:0]   out_mean_score
);
  import ufs_pkg::*;

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int FW  = $clog2(TABLE_DEPTH + 1);
  localparam int NW  = SUM_W + FRACTION_BITS;
  localparam int DW  = COUNT_W + 1;
  localparam int CW  = $clog2(NW + 1);
  localparam logic [FW-1:0] DEPTH_F = FW'(TABLE_DEPTH);

  typedef enum logic [2:0] {S_IDLE, S_PROBE, S_WAIT, S_CMP, S_DIV, S_OUT} state_t;

  logic [KEY_W-1:0] keys_m   [TABLE_DEPTH];
  logic [7:0]       scores_m [TABLE_DEPTH];

  state_t           state_r;
  logic [FW-1:0]    fill_r;
  logic [FW:0]      lo_r, hi_r;
  logic [AW-1:0]    mid_r;
  logic [KEY_W-1:0] key_r, rkey_r;
  logic [7:0]       rsc_r;
  logic [SUM_W-1:0] sum_r;
  logic [COUNT_W-1:0] cnt_r;
  logic [NW-1:0]    num_r;
  logic [DW-1:0]    div_r;
  logic [DW:0]      rem_r;
  logic [CW-1:0]    step_r;
  logic             wr_en, rd_en;
  logic [AW-1:0]    rd_addr;
  logic [FW:0]      mid_w;
  logic [DW:0]      trial;
  logic [SUM_W:0]   sum_add;
  logic [SUM_W-1:0] sum_s;
  logic [SUM_W-1:0] ot_r;
  logic [COUNT_W-1:0] oc_r;
  logic [MEAN_W-1:0] om_r;

  assign job_ready = (state_r == S_IDLE) && !(out_valid && job.op == OP_FINISH);
  assign wr_en  = job_valid && job_ready && job.op == OP_LOAD && fill_r != DEPTH_F;
  assign mid_w  = lo_r + ((hi_r - lo_r - (FW+1)'(1)) >> 1);
  assign rd_en  = state_r == S_PROBE;
  assign rd_addr = mid_w[AW-1:0];
  assign trial  = {rem_r[DW-1:0], num_r[NW-1]};
  assign sum_add = {1'b0, sum_r} + {{(SUM_W-7){1'b0}}, rsc_r};
  assign sum_s  = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
  assign out_score_total = ot_r;
  assign out_char_total  = oc_r;
  assign out_mean_score  = om_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      keys_m[fill_r[AW-1:0]]   <= job.key;
      scores_m[fill_r[AW-1:0]] <= job.score;
    end
    if (rd_en) begin
      rkey_r <= keys_m[rd_addr];
      rsc_r  <= scores_m[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      fill_r    <= '0;
      sum_r     <= '0;
      cnt_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (wr_en) fill_r <= fill_r + FW'(1);
      unique case (state_r)
        S_IDLE: begin
          if (job_valid && job_ready) begin
            key_r <= job.key;
            if (job.op == OP_LOOKUP) begin
              lo_r    <= '0;
              hi_r    <= {1'b0, fill_r};
              state_r <= S_PROBE;
              if (cnt_r != '1) cnt_r <= cnt_r + COUNT_W'(1);
            end else if (job.op == OP_FINISH) begin
              ot_r   <= sum_r;
              oc_r   <= cnt_r;
              num_r  <= (cnt_r == '0) ? '0 : {sum_r, {FRACTION_BITS{1'b0}}};
              div_r  <= {1'b0, cnt_r} + DW'(job.omitted);
              rem_r  <= '0;
              step_r <= CW'(NW);
              state_r <= (cnt_r == '0) ? S_OUT : S_DIV;
            end
          end
        end
        S_PROBE: begin
          if (lo_r >= hi_r) state_r <= S_IDLE;
          else begin
            mid_r   <= mid_w[AW-1:0];
            state_r <= S_WAIT;
          end
        end
        S_WAIT: state_r <= S_CMP;
        S_CMP: begin
          if (key_r < rkey_r) begin
            hi_r <= (FW+1)'(mid_r);
            state_r <= S_PROBE;
          end else if (rkey_r < key_r) begin
            lo_r <= (FW+1)'(mid_r) + (FW+1)'(1);
            state_r <= S_PROBE;
          end else begin
            sum_r <= sum_s;
            state_r <= S_IDLE;
          end
        end
        S_DIV: begin
          if (trial >= {1'b0, div_r}) begin
            rem_r <= trial - {1'b0, div_r};
            num_r <= {num_r[NW-2:0], 1'b1};
          end else begin
            rem_r <= trial;
            num_r <= {num_r[NW-2:0], 1'b0};
          end
          step_r <= step_r - CW'(1);
          if (step_r == CW'(1)) state_r <= S_OUT;
        end
        S_OUT: begin
          om_r <= (num_r > NW'({MEAN_W{1'b1}})) ? '1 : num_r[MEAN_W-1:0];
          out_valid <= 1'b1;
          sum_r   <= '0;
          cnt_r   <= '0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* sim/utf8_frequency_scorer_chk.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_frequency_scorer_chk
// Watches both channels of the scorer, keeps its own copy of the weight table
// and the text parser, predicts each finish report and compares it field by
// field with what the block returns.
// ----------------------------------------------------------------------------
module utf8_frequency_scorer_chk #(
  parameter int TABLE_DEPTH   = 4096,
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_text_byte,
  input  logic [4:0]  in_entry_class,
  input  logic [15:0] in_entry_code,
  input  logic [7:0]  in_entry_score,
  input  logic [2:0]  in_omitted_bytes,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_score_total,
  input  logic [23:0] out_char_total,
  input  logic [23:0] out_mean_score,
  output int          mismatches,
  output int          reports_due
);
  import ufs_pkg::*;

  typedef enum logic [1:0] {
    PARSE_IDLE  = 2'd0,
    PARSE_TWO   = 2'd1,
    PARSE_THREE = 2'd2,
    PARSE_SKIP  = 2'd3
  } parse_t;

  typedef struct packed {
    logic [SUM_W-1:0]   score_total;
    logic [COUNT_W-1:0] char_total;
    logic [MEAN_W-1:0]  mean_score;
  } report_t;

  logic [KEY_W-1:0]   weight_keys [TABLE_DEPTH];
  logic [7:0]         weight_vals [TABLE_DEPTH];
  int                 weight_fill;
  int                 pending;
  parse_t             kind;
  logic [7:0]         lead;
  logic [7:0]         middle;
  logic [SUM_W-1:0]   running_sum;
  logic [COUNT_W-1:0] running_count;
  report_t            reports_owed [$];

  assign reports_due = reports_owed.size();

  function automatic logic [7:0] weight_of(logic [KEY_W-1:0] key);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = weight_fill - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (key < weight_keys[mid]) hi = mid - 1;
      else if (weight_keys[mid] < key) lo = mid + 1;
      else return weight_vals[mid];
    end
    return 8'd0;
  endfunction

  task automatic score_char(logic [KEY_W-1:0] key);
    logic [7:0] w;
    w = weight_of(key);
    if (running_sum > {SUM_W{1'b1}} - w) running_sum = {SUM_W{1'b1}};
    else running_sum = running_sum + w;
    if (running_count != {COUNT_W{1'b1}}) running_count = running_count + 1'b1;
  endtask

  task automatic clear_parse();
    pending = 0;
    kind    = PARSE_IDLE;
    lead    = 8'd0;
    middle  = 8'd0;
  endtask

  task automatic take_byte(logic [7:0] b);
    logic [4:0] cls;
    if (pending != 0) begin
      pending--;
      if (kind == PARSE_TWO) begin
        score_char({5'd0, lead, b});
        clear_parse();
      end else if (kind == PARSE_THREE) begin
        if (pending == 1) begin
          middle = b;
        end else begin
          cls = 5'd1 + {1'b0, lead[3:0] & NIBBLE_LO[3:0]};
          score_char({cls, middle, b});
          clear_parse();
        end
      end else if (pending == 0) begin
        clear_parse();
      end
    end else if (b > ASCII_MAX) begin
      if ((b & LEAD_SKIP) == LEAD_SKIP) begin
        kind = PARSE_SKIP;
        pending = 3;
      end else if ((b & LEAD_THREE) == LEAD_THREE) begin
        kind = PARSE_THREE;
        lead = b;
        pending = 2;
      end else if ((b & LEAD_TWO) == LEAD_TWO) begin
        kind = PARSE_TWO;
        lead = b;
        pending = 1;
      end else begin
        kind = PARSE_SKIP;
        pending = 4;
      end
    end
  endtask

  task automatic close_text(logic [2:0] omitted);
    report_t    r;
    logic [63:0] quot;
    quot = 64'd0;
    if (running_count != 0) begin
      quot = ({32'd0, running_sum} << FRACTION_BITS) / (64'(running_count) + 64'(omitted));
      if (quot > 64'hFF_FFFF) quot = 64'hFF_FFFF;
    end
    r.score_total = running_sum;
    r.char_total  = running_count;
    r.mean_score  = quot[MEAN_W-1:0];
    reports_owed.push_back(r);
    clear_parse();
    running_sum   = '0;
    running_count = '0;
  endtask

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got 0x%0h, expected 0x%0h", $realtime, field, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    report_t want;
    if (!rst_n) begin
      weight_fill   = 0;
      running_sum   = '0;
      running_count = '0;
      mismatches    = 0;
      clear_parse();
      reports_owed.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (reports_owed.size() == 0) begin
          $display("mismatch at %0t: report with none outstanding", $realtime);
          mismatches++;
        end else begin
          want = reports_owed.pop_front();
          if (out_score_total !== want.score_total)
            report("score_total", out_score_total, want.score_total);
          if (out_char_total !== want.char_total)
            report("char_total", 32'(out_char_total), 32'(want.char_total));
          if (out_mean_score !== want.mean_score)
            report("mean_score", 32'(out_mean_score), 32'(want.mean_score));
        end
      end
      if (in_valid && in_ready) begin
        case (in_command)
          CMD_LOAD: begin
            if (weight_fill < TABLE_DEPTH) begin
              weight_keys[weight_fill] = {in_entry_class, in_entry_code};
              weight_vals[weight_fill] = in_entry_score;
              weight_fill++;
            end
          end
          CMD_BYTE:   take_byte(in_text_byte);
          CMD_FINISH: close_text(in_omitted_bytes);
          default: ;
        endcase
      end
    end
  end

endmodule

/* sim/utf8_frequency_scorer_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_frequency_scorer_tb
// Loads a sorted weight table, feeds directed and random UTF-8 text with
// random handshake gaps on both sides, and gives the verdict from the
// checker's mismatch count.
// ----------------------------------------------------------------------------
module utf8_frequency_scorer_tb;
  import ufs_pkg::*;

  localparam int CMD_UNUSED  = 3;
  localparam int STALL_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_command = CMD_BYTE;
  logic [7:0]  in_text_byte = '0;
  logic [4:0]  in_entry_class = '0;
  logic [15:0] in_entry_code = '0;
  logic [7:0]  in_entry_score = '0;
  logic [2:0]  in_omitted_bytes = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_score_total;
  logic [23:0] out_char_total;
  logic [23:0] out_mean_score;
  int          mismatches;
  int          reports_due;
  int          idle_cycles = 0;
  logic [KEY_W-1:0] loaded_keys [$];
  logic [KEY_W-1:0] top_key;

  always #5 clk = ~clk;

  utf8_frequency_scorer u_top (.*);

  utf8_frequency_scorer_chk u_chk (.*);

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(negedge clk) begin
    int hold;
    if ($urandom_range(0, 3) == 0) begin
      out_ready = 1'b0;
      hold = gap_len();
      repeat (hold) @(negedge clk);
    end
    out_ready = 1'b1;
    hold = $urandom_range(0, 20);
    repeat (hold) @(negedge clk);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send(logic [1:0] cmd, logic [7:0] b, logic [4:0] cls, logic [15:0] code,
                      logic [7:0] score, logic [2:0] omitted);
    int gap;
    gap = gap_len();
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_command       = cmd;
    in_text_byte     = b;
    in_entry_class   = cls;
    in_entry_code    = code;
    in_entry_score   = score;
    in_omitted_bytes = omitted;
    in_valid         = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic text_byte(logic [7:0] b);
    send(CMD_BYTE, b, 5'($urandom), 16'($urandom), 8'($urandom), 3'($urandom));
  endtask

  task automatic load_entry(logic [KEY_W-1:0] key, logic [7:0] score);
    send(CMD_LOAD, 8'($urandom), key[20:16], key[15:0], score, 3'($urandom));
  endtask

  task automatic finish_text(logic [2:0] omitted);
    send(CMD_FINISH, 8'($urandom), 5'($urandom), 16'($urandom), 8'($urandom), omitted);
  endtask

  task automatic unused_cmd();
    send(2'(CMD_UNUSED), 8'($urandom), 5'($urandom), 16'($urandom), 8'($urandom),
         3'($urandom));
  endtask

  task automatic text_char(logic [KEY_W-1:0] key);
    if (key[20:16] == 5'd0) begin
      text_byte(key[15:8]);
      text_byte(key[7:0]);
    end else begin
      text_byte({4'hE, 4'(key[20:16] - 5'd1)});
      text_byte(key[15:8]);
      text_byte(key[7:0]);
    end
  endtask

  function automatic logic [KEY_W-1:0] pick_char();
    logic [KEY_W-1:0] k;
    int tries;
    for (tries = 0; tries < 8; tries++) begin
      k = loaded_keys[$urandom_range(0, loaded_keys.size() - 1)];
      if (k[20:16] >= 5'd1 && k[20:16] <= 5'd16) return k;
      if (k[20:16] == 5'd0 && k[15:13] == 3'b110) return k;
    end
    if ($urandom_range(0, 1) == 0) return {5'd0, 3'b110, 13'($urandom)};
    return {5'($urandom_range(1, 16)), 16'($urandom)};
  endfunction

  initial begin
    int n;
    int len;
    int i;
    int r;
    logic [KEY_W-1:0] k;

    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // sorted table: two-byte and three-byte classes, with some holes
    k = KEY_W'($urandom_range(0, 2000));
    while (k < {5'd17, 16'd0}) begin
      loaded_keys.push_back(k);
      k = k + KEY_W'($urandom_range(1, 40000));
    end
    loaded_keys.push_back({5'd0, 8'hC3, 8'hA9});
    loaded_keys.push_back({5'd3, 8'h82, 8'hAC});
    loaded_keys.sort();
    loaded_keys = loaded_keys.unique();
    foreach (loaded_keys[j]) load_entry(loaded_keys[j], (j == 0) ? 8'hFF : 8'($urandom));
    top_key = loaded_keys[$];

    text_byte(8'h00);
    text_byte(ASCII_MAX);
    text_byte(8'hC3); text_byte(8'hA9);
    text_byte(8'hE2); text_byte(8'h82); text_byte(8'hAC);
    text_byte(8'hC5); text_byte(8'h01);
    text_byte(8'hFF); text_byte(8'hC3); text_byte(8'hA9); text_byte(8'h41);
    text_byte(8'h80); text_byte(8'hC3); text_byte(8'hA9); text_byte(8'hE2); text_byte(8'h82);
    unused_cmd();
    finish_text(3'd0);
    finish_text(3'd7);
    text_char(loaded_keys[0]);
    text_byte(8'hE2); text_byte(8'h82);
    finish_text(3'd5);
    text_byte(8'hDF); text_byte(8'hBF);
    finish_text(3'd0);

    n = 0;
    while (n < 1650) begin
      len = $urandom_range(1, 30);
      for (i = 0; i < len; i++) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          k = pick_char();
          text_char(k);
          n += (k[20:16] == 5'd0) ? 2 : 3;
        end else if (r < 88) begin
          text_byte(8'($urandom));
          n++;
        end else if (r < 93) begin
          text_byte(8'($urandom_range(0, 127)));
          n++;
        end else if (r < 96) begin
          top_key = top_key + KEY_W'($urandom_range(1, 5000));
          if (top_key[20:16] < 5'd17) top_key = {5'd17, 16'($urandom)};
          load_entry(top_key, 8'($urandom));
          n++;
        end else if (r < 98) begin
          unused_cmd();
          n++;
        end else if (n > 1400) begin
          load_entry(KEY_W'($urandom), 8'($urandom));
          n++;
        end
      end
      finish_text(3'($urandom_range(0, 7)));
      n++;
    end

    in_valid = 1'b0;
    while (reports_due != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
